### hdl/ovl_pkg.sv
`timescale 1ns / 1ps

package ovl_pkg;

  // Widths that follow from the fields of a request and a result.
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 7;
  // Cell index width, sized for the largest supported list.
  localparam int unsigned IDX_W = 6;

  typedef enum logic [1:0] {
    CMD_APPEND       = 2'd0,
    CMD_REMOVE_FIRST = 2'd1,
    CMD_REMOVE_ALL   = 2'd2,
    CMD_SHOW         = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [VAL_W-1:0] wr_data;
  } cell_ctl_t;

endpackage

### hdl/ovl_if.sv
`timescale 1ns / 1ps

interface ovl_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface ovl_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] value_res;
  logic [6:0]         count;
  logic               last;

  modport source (output valid, output status, output value_res, output count,
                  output last, input ready);
  modport sink (input valid, input status, input value_res, input count,
                input last, output ready);
endinterface

### hdl/ovl_cell.sv
`timescale 1ns / 1ps

module ovl_cell
  import ovl_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [VAL_W-1:0] nbr_i,
  output logic [VAL_W-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [VAL_W-1:0] data_q;
  logic [VAL_W-1:0] data_d;

  // A direct write wins over the shift toward the head.
  always_comb begin
    data_d = data_q;
    if (ctl_i.wr_en && (ctl_i.wr_idx == MyIdx)) begin
      data_d = ctl_i.wr_data;
    end else if (ctl_i.shift) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hdl/ordered_value_list.sv
`timescale 1ns / 1ps

// Channel  | Role   | Payload
// ---------+--------+----------------------------------------------
// req_i    | sink   | command[1:0], value[31:0] signed
// rsp_o    | source | status[1:0], value_res[31:0] signed, count[6:0], last
//
// For append, and for any command on an empty list, the result is loaded
// into the output register on the cycle the request is accepted.
// Remove-first, remove-all and show walk the cell chain, one stored entry
// per cycle while the output register is free; no new request is taken
// until the walk ends. A stalled response stalls the walk.
// Reset (rst_ni, asynchronous, active low) clears the count and control only.
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ovl_req_if.sink   req_i,
  ovl_rsp_if.source rsp_o
);

  // The list lives in a chain of cells, head in cell 0. A walk pops the head
  // every cycle that the output register is free, while the whole chain shifts
  // one place toward the head. An entry that survives is written back behind
  // the entries still waiting, so after as many steps as there were entries the
  // survivors sit compacted at the head in their original order. Show keeps
  // every entry and emits each one as it passes the head.

  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  // Entries not yet visited by the walk.
  logic [CNT_W-1:0] left_q, left_d;
  // Entries not yet visited plus entries already kept.
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             hit_q, hit_d;
  cmd_e             cmd_q, cmd_d;
  logic [VAL_W-1:0] val_q, val_d;

  // Output register, which decouples the response side from the walk.
  logic             o_valid_q, o_valid_d;
  logic             o_load;
  status_e          o_status_d, o_status_q;
  logic [VAL_W-1:0] o_value_d, o_value_q;
  logic [CNT_W-1:0] o_count_d, o_count_q;
  logic             o_last_d, o_last_q;

  cell_ctl_t        ctl;
  logic [VAL_W-1:0] cell_data [CAPACITY];

  logic             out_free;
  logic             accept;
  logic             step;
  logic [VAL_W-1:0] head;
  logic             drop;
  logic             final_step;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] fill_m1;

  assign out_free    = !o_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == StIdle) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign step        = (state_q == StWalk) && out_free;

  assign head       = cell_data[0];
  assign drop       = (cmd_q != CMD_SHOW) && (head == val_q) &&
                      ((cmd_q == CMD_REMOVE_ALL) || !hit_q);
  assign final_step = (left_q == CNT_W'(1));
  assign fill_m1    = fill_q - CNT_W'(1);
  assign fill_next  = drop ? fill_m1 : fill_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    fill_d     = fill_q;
    hit_d      = hit_q;
    cmd_d      = cmd_q;
    val_d      = val_q;
    o_valid_d  = o_valid_q;
    o_load     = 1'b0;
    o_status_d = ST_OK;
    o_value_d  = '0;
    o_count_d  = cnt_q;
    o_last_d   = 1'b1;
    ctl        = '0;

    if (o_valid_q && rsp_o.ready) begin
      o_valid_d = 1'b0;
    end

    if (accept) begin
      cmd_d = cmd_e'(req_i.command);
      val_d = req_i.value;
      if (cmd_e'(req_i.command) == CMD_APPEND) begin
        o_load = 1'b1;
        if (cnt_q >= CapC) begin
          o_status_d = ST_FULL;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_idx  = cnt_q[IDX_W-1:0];
          ctl.wr_data = req_i.value;
          cnt_d       = cnt_q + CNT_W'(1);
          o_count_d   = cnt_q + CNT_W'(1);
        end
      end else if (cnt_q == '0) begin
        o_load     = 1'b1;
        o_status_d = ST_EMPTY;
      end else begin
        state_d = StWalk;
        left_d  = cnt_q;
        fill_d  = cnt_q;
        hit_d   = 1'b0;
      end
    end

    if (step) begin
      ctl.shift   = 1'b1;
      ctl.wr_en   = !drop;
      ctl.wr_idx  = fill_m1[IDX_W-1:0];
      ctl.wr_data = head;
      left_d      = left_q - CNT_W'(1);
      fill_d      = fill_next;
      hit_d       = hit_q || drop;
      if (cmd_q == CMD_SHOW) begin
        // One response per entry; last marks the tail.
        o_load    = 1'b1;
        o_value_d = head;
        o_last_d  = final_step;
      end else if (final_step) begin
        o_load     = 1'b1;
        o_status_d = (hit_q || drop) ? ST_OK : ST_NOT_FOUND;
        o_count_d  = fill_next;
      end
      if (final_step) begin
        state_d = StIdle;
        cnt_d   = fill_next;
      end
    end

    if (o_load) begin
      o_valid_d = 1'b1;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_tail
      assign nbr = cell_data[i];
    end else begin : g_body
      assign nbr = cell_data[i+1];
    end
    ovl_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .nbr_i (nbr),
      .data_o(cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      left_q    <= '0;
      fill_q    <= '0;
      hit_q     <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      fill_q    <= fill_d;
      hit_q     <= hit_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    if (o_load) begin
      o_status_q <= o_status_d;
      o_value_q  <= o_value_d;
      o_count_q  <= o_count_d;
      o_last_q   <= o_last_d;
    end
  end

  assign rsp_o.valid     = o_valid_q;
  assign rsp_o.status    = o_status_q;
  assign rsp_o.value_res = o_value_q;
  assign rsp_o.count     = o_count_q;
  assign rsp_o.last      = o_last_q;

endmodule

### dv/tb_ordered_value_list.sv
`timescale 1ns / 1ps

module tb_ordered_value_list;
  import ovl_pkg::*;

  localparam int unsigned LIST_DEPTH      = 16;
  localparam int unsigned RANDOM_REQUESTS = 300;
  localparam int unsigned HOLDOFF_CYCLES  = 200;
  localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX  = 32'sh7fff_ffff;

  // One response as the list should produce it.
  typedef struct {
    status_e            status;
    logic signed [31:0] value_res;
    logic [6:0]         count;
    logic               last;
  } list_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ovl_req_if req ();
  ovl_rsp_if rsp ();

  ordered_value_list #(
    .CAPACITY (LIST_DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Shadow copy of the stored list, head at index 0, and the responses that
  // accepted requests still owe, oldest first.
  logic signed [31:0] list_model[$];
  list_result_t       pending_results[$];

  int unsigned fail_count  = 0;
  // When clear, neither side inserts random gaps.
  bit          idle_en     = 1'b1;
  // A nonzero value asks the response side to hold ready low for a stretch set
  // by that value; the ready process picks it up and clears it.
  int unsigned holdoff_req = 0;

  always #5 clk_i = ~clk_i;

  // Gap length for either side: mostly none, often short, now and then a long
  // one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Values for random requests. A small pool makes removals hit and produces
  // duplicates; the rest covers the extremes and the whole 32-bit range.
  function automatic logic signed [31:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed($urandom_range(0, 5)) - 2;
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void note_result(status_e status, logic signed [31:0] val,
                                      int unsigned cnt, logic last);
    list_result_t r;
    r.status    = status;
    r.value_res = val;
    r.count     = 7'(cnt);
    r.last      = last;
    pending_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow list and queues every response
  // that it owes.
  function automatic void apply_command(cmd_e cmd, logic signed [31:0] val);
    logic signed [31:0] kept[$];
    bit hit;
    case (cmd)
      CMD_APPEND: begin
        // A full list keeps its contents and reports full with the old count.
        if (list_model.size() >= LIST_DEPTH) begin
          note_result(ST_FULL, 0, list_model.size(), 1'b1);
        end else begin
          list_model.push_back(val);
          note_result(ST_OK, 0, list_model.size(), 1'b1);
        end
      end
      CMD_SHOW: begin
        // An empty list still gives one response, flagged as the last.
        if (list_model.size() == 0) begin
          note_result(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          foreach (list_model[i]) begin
            note_result(ST_OK, list_model[i], list_model.size(),
                        (i == list_model.size() - 1));
          end
        end
      end
      default: begin
        if (list_model.size() == 0) begin
          note_result(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          // Walk from the head and keep every survivor in order. Remove-first
          // drops only the earliest match; remove-all drops each one, the head
          // included.
          hit = 1'b0;
          foreach (list_model[i]) begin
            if (list_model[i] == val && (cmd == CMD_REMOVE_ALL || !hit)) begin
              hit = 1'b1;
            end else begin
              kept.push_back(list_model[i]);
            end
          end
          list_model = kept;
          note_result(hit ? ST_OK : ST_NOT_FOUND, 0, list_model.size(), 1'b1);
        end
      end
    endcase
  endfunction

  // Offers one request after an optional gap and returns at the edge where it
  // is accepted. Valid is only lowered when a gap follows, so back-to-back
  // requests keep it high without a glitch.
  task automatic send_request(input cmd_e cmd, input logic signed [31:0] val);
    int unsigned gap;
    gap = idle_en ? gap_len() : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.value   <= val;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    apply_command(cmd, val);
  endtask

  // Withdraws the request that was just accepted and waits until every owed
  // response has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Remove and show on a list that has never held anything.
  task automatic test_empty_list();
    send_request(CMD_SHOW, 0);
    send_request(CMD_REMOVE_FIRST, VAL_MIN);
  endtask

  // Fill to capacity with the field extremes and some duplicates, then try
  // one more append and show the full list.
  task automatic test_fill_and_full();
    logic signed [31:0] fill_vals[16] = '{
      5, VAL_MIN, VAL_MAX, 0, -1, 5, 7, 32'sh5555_5555,
      7, 5, 32'shAAAA_AAAA, 1, -2, 100, 12345, -12345
    };
    foreach (fill_vals[i]) send_request(CMD_APPEND, fill_vals[i]);
    send_request(CMD_APPEND, VAL_MAX);
    send_request(CMD_SHOW, 0);
  endtask

  // Removals that take the head, that leave a later duplicate in place, and
  // that find nothing.
  task automatic test_removals();
    // The head holds 5, so the walk has to go on correctly after dropping it.
    send_request(CMD_REMOVE_ALL, 5);
    send_request(CMD_REMOVE_FIRST, VAL_MIN);
    send_request(CMD_REMOVE_FIRST, 7);
    send_request(CMD_REMOVE_ALL, 5);
    send_request(CMD_SHOW, 0);
    wait_drained();
  endtask

  // The response side stops for a long stretch while requests keep coming,
  // so the output register fills and the block stops taking requests.
  task automatic test_backpressure();
    idle_en     = 1'b0;
    holdoff_req = HOLDOFF_CYCLES;
    send_request(CMD_SHOW, 0);
    send_request(CMD_APPEND, 3);
    send_request(CMD_SHOW, 0);
    send_request(CMD_REMOVE_ALL, 7);
    send_request(CMD_APPEND, -3);
    send_request(CMD_SHOW, 0);
    wait_drained();
    idle_en = 1'b1;
  endtask

  // Alternating phases that grow and shrink the list, so it spends time
  // empty, full and in between, with and without gaps on both sides.
  task automatic test_random_mix();
    int unsigned phase;
    int unsigned grow_pct;
    cmd_e        cmd;
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      phase    = i / 40;
      grow_pct = (phase % 2 == 0) ? 70 : 25;
      idle_en  = (phase % 3 != 2);
      if ($urandom_range(0, 99) < grow_pct) begin
        cmd = CMD_APPEND;
      end else begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_REMOVE_FIRST;
          1: cmd = CMD_REMOVE_ALL;
          default: cmd = CMD_SHOW;
        endcase
      end
      send_request(cmd, rand_value());
    end
    idle_en = 1'b1;
  endtask

  // Drives ready for the response side: random stalls, or a long hold-off
  // when a test asks for one. At most one assignment per clock edge.
  initial begin : rsp_ready_gen
    int unsigned stall_left;
    int unsigned n;
    stall_left = 0;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holdoff_req != 0) begin
        n           = holdoff_req;
        holdoff_req = 0;
        stall_left  = 0;
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        n = idle_en ? gap_len() : 0;
        if (n == 0) begin
          rsp.ready <= 1'b1;
        end else begin
          rsp.ready <= 1'b0;
          stall_left = n - 1;
        end
      end
    end
  end

  // Compares every accepted response with the oldest one still owed.
  always @(posedge clk_i) begin : result_check
    list_result_t exp_r;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d value_res %0d count %0d last %0d",
               rsp.status, rsp.value_res, rsp.count, rsp.last);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, rsp.status);
          fail_count++;
        end
        if (rsp.value_res !== exp_r.value_res) begin
          $error("value_res: expected %0d, actual %0d", exp_r.value_res,
                 rsp.value_res);
          fail_count++;
        end
        if (rsp.count !== exp_r.count) begin
          $error("count: expected %0d, actual %0d", exp_r.count, rsp.count);
          fail_count++;
        end
        if (rsp.last !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, rsp.last);
          fail_count++;
        end
      end
    end
  end

  initial begin : test_seq
    req.valid   <= 1'b0;
    req.command <= CMD_APPEND;
    req.value   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_and_full();
    test_removals();
    test_backpressure();
    test_random_mix();
    wait_drained();
    // A walk covers at most the whole list; anything arriving later is extra.
    repeat (4 * LIST_DEPTH) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The slowest correct run, with every show at full length and every
  // response stalled as long as possible, stays well inside this bound.
  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
